// ===== design/relay_switch_guard_macros.svh =====
// Assertion macros for the relay switch guard.
// Used by the top level only; expects clk and rst_n at the point of use.
`ifndef RELAY_SWITCH_GUARD_MACROS_SVH
`define RELAY_SWITCH_GUARD_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RSG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("relay_switch_guard: check failed");

// Next-cycle implication, disabled during reset.
`define RSG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("relay_switch_guard: check failed");

`endif

// ===== design/rsg_pkg.sv =====
// Shared types and constants for the relay switch guard.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package rsg_pkg;

    // Item modes
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_SET    = 3'd1;
    localparam logic [2:0] MODE_TOGGLE = 3'd2;
    localparam logic [2:0] MODE_PULSE  = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_INVERT_LEVEL    = 2'd0;
    localparam logic [1:0] REG_MAX_SWITCH_HZ   = 2'd1;
    localparam logic [1:0] REG_SAFETY_ENABLE   = 2'd2;
    localparam logic [1:0] REG_SAFETY_LIMIT_MS = 2'd3;

    localparam logic [9:0]  MS_PER_SECOND = 10'd1000;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]  mode;
        logic        want_on;
        logic [31:0] pulse_ms;
    } in_item_t;

    typedef struct packed {
        logic        pin_level;
        logic        relay_on;
        logic        status;
        logic        changed;
        logic        pulse_expired;
        logic        safety_tripped;
        logic [31:0] switch_total;
        logic [47:0] on_total_ms;
        logic [47:0] off_total_ms;
        logic [31:0] since_switch_ms;
    } out_item_t;

    // Settings seen by the core
    typedef struct packed {
        logic        invert_level;
        logic        safety_enable;
        logic [31:0] safety_limit_ms;
        logic [9:0]  min_interval;
    } cfg_t;

endpackage

// ===== design/rsg_div.sv =====
// Iterative restoring divider: min_interval = 1000 / max_switch_hz.
// One quotient bit per cycle; uses rsg_pkg constants.
`timescale 1ns / 1ps

module rsg_div (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [9:0] divisor,
    output logic       busy,
    output logic [9:0] quotient
);

    localparam int STEPS = 10;

    logic       busy_reg;
    logic [3:0] cnt_reg;
    logic [9:0] rem_reg;
    logic [9:0] dq_reg;
    logic [9:0] d_reg;
    logic [9:0] q_reg;

    logic [10:0] rem_sh;
    logic        qbit;
    logic [10:0] rem_next;

    always_comb
    begin
        rem_sh   = {rem_reg, dq_reg[9]};
        qbit     = rem_sh >= {1'b0, d_reg};
        rem_next = qbit ? (rem_sh - {1'b0, d_reg}) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= '0;
        end
        else if (start)
        begin
            if (divisor == '0)
            begin
                busy_reg <= 1'b0;
                q_reg    <= '0;     // zero hertz: no limit
            end
            else
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 4'(STEPS);
            end
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_reg <= 1'b0;
                q_reg    <= {dq_reg[8:0], qbit};
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= rsg_pkg::MS_PER_SECOND;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[9:0];
            dq_reg  <= {dq_reg[8:0], qbit};
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// ===== design/rsg_core.sv =====
// Relay state, timers, pulse and statistics; next state from one item.
// Uses rsg_pkg types; state advances when step is high.
`timescale 1ns / 1ps

module rsg_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rsg_pkg::in_item_t item,
    input  rsg_pkg::cfg_t     cfg,
    output rsg_pkg::out_item_t result
);

    logic        is_on_reg, is_on_next;
    logic [31:0] since_reg, since_next;
    logic [31:0] ist_reg, ist_next;
    logic [31:0] count_reg, count_next;
    logic [47:0] on_sum_reg, on_sum_next;
    logic [47:0] off_sum_reg, off_sum_next;
    logic        armed_reg, armed_next;
    logic [31:0] left_reg, left_next;

    logic        tick, try_cmd, target, too_fast, refused;
    logic        pulse_end, rate_sw, trip, sw;
    logic [31:0] since_eff, ist_eff;
    logic [48:0] credit_sum;
    logic [47:0] credit_sat;

    always_comb
    begin
        tick      = item.mode == rsg_pkg::MODE_TICK;
        since_eff = (tick && since_reg != rsg_pkg::MAX32) ? since_reg + 32'd1 : since_reg;
        ist_eff   = (tick && ist_reg != rsg_pkg::MAX32) ? ist_reg + 32'd1 : ist_reg;
        too_fast  = cfg.min_interval != '0 && since_eff < {22'd0, cfg.min_interval};
        pulse_end = tick && armed_reg && left_reg <= 32'd1;

        case (item.mode)
            rsg_pkg::MODE_SET:    target = item.want_on;
            rsg_pkg::MODE_TOGGLE: target = !is_on_reg;
            rsg_pkg::MODE_PULSE:  target = 1'b1;
            default:              target = 1'b0;   // pulse end switches off
        endcase
        try_cmd = pulse_end || item.mode == rsg_pkg::MODE_SET
               || item.mode == rsg_pkg::MODE_TOGGLE || item.mode == rsg_pkg::MODE_PULSE;

        refused = try_cmd && too_fast;
        rate_sw = try_cmd && !too_fast && target != is_on_reg;
        // safety trip ignores the rate limit; only if still on
        trip = tick && cfg.safety_enable && is_on_reg && !rate_sw
            && ist_eff >= cfg.safety_limit_ms;
        sw = rate_sw || trip;

        // time spent in the state being left
        credit_sum = {1'b0, (is_on_reg ? on_sum_reg : off_sum_reg)} + {17'd0, ist_eff};
        credit_sat = credit_sum[48] ? rsg_pkg::MAX48 : credit_sum[47:0];

        is_on_next   = sw ? !is_on_reg : is_on_reg;
        since_next   = sw ? '0 : since_eff;
        ist_next     = sw ? '0 : ist_eff;
        count_next   = count_reg;
        on_sum_next  = on_sum_reg;
        off_sum_next = off_sum_reg;
        if (sw)
        begin
            if (count_reg != rsg_pkg::MAX32)
                count_next = count_reg + 32'd1;
            if (is_on_reg)
                on_sum_next = credit_sat;
            else
                off_sum_next = credit_sat;
        end
        if (item.mode == rsg_pkg::MODE_CLEAR)
        begin
            count_next   = '0;
            on_sum_next  = '0;
            off_sum_next = '0;
        end

        armed_next = armed_reg;
        left_next  = left_reg;
        if (pulse_end)
        begin
            armed_next = 1'b0;
            left_next  = '0;
        end
        else if (tick && armed_reg)
            left_next = left_reg - 32'd1;
        else if (item.mode == rsg_pkg::MODE_PULSE && !refused)
        begin
            armed_next = 1'b1;
            left_next  = item.pulse_ms;
        end

        result.pin_level       = is_on_next ^ cfg.invert_level;
        result.relay_on        = is_on_next;
        result.status          = refused;
        result.changed         = sw;
        result.pulse_expired   = pulse_end;
        result.safety_tripped  = trip;
        result.switch_total    = count_next;
        result.on_total_ms     = on_sum_next;
        result.off_total_ms    = off_sum_next;
        result.since_switch_ms = since_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_on_reg   <= 1'b0;
            since_reg   <= '0;
            ist_reg     <= '0;
            count_reg   <= '0;
            on_sum_reg  <= '0;
            off_sum_reg <= '0;
            armed_reg   <= 1'b0;
            left_reg    <= '0;
        end
        else if (step)
        begin
            is_on_reg   <= is_on_next;
            since_reg   <= since_next;
            ist_reg     <= ist_next;
            count_reg   <= count_next;
            on_sum_reg  <= on_sum_next;
            off_sum_reg <= off_sum_next;
            armed_reg   <= armed_next;
            left_reg    <= left_next;
        end
    end

endmodule

// ===== design/relay_switch_guard.sv =====
// Relay switch guard top level: APB registers, input and result registers.
// Depends on rsg_pkg, rsg_div, rsg_core and relay_switch_guard_macros.svh.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one beat per 1 ms tick or command.
//   out channel (out_valid/out_ready/out_data): exactly one result beat per
//   input beat, in order, carrying the relay state and statistics after it.
//   A beat accepted is captured in the input register, processed by the core
//   once the result slot is free, and shown on out_data from the result register.
//   One beat per cycle while out_ready is high and no division runs: the input
//   register refills in the same cycle its beat moves into the result register.
//   If the receiver stalls, the result register holds; one more beat can
//   still be taken into the input register, after which in_ready drops.
//   APB: registers at byte 0x0 invert_level, 0x4 max_switch_hz,
//   0x8 safety_enable, 0xC safety_limit_ms; pready is always high.
//   A write to max_switch_hz starts a bit-serial division for the
//   minimum switch interval; in_ready is low while it runs.
//   Reset: relay off, all timers, totals and configuration registers zero,
//   both channels empty.
`timescale 1ns / 1ps
`include "relay_switch_guard_macros.svh"

module relay_switch_guard (
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // item input
    input  logic               in_valid,
    output logic               in_ready,
    input  rsg_pkg::in_item_t  in_data,
    // result output
    output logic               out_valid,
    input  logic               out_ready,
    output rsg_pkg::out_item_t out_data
);

    // configuration registers
    logic        invert_reg;
    logic [9:0]  hz_reg;
    logic        safety_en_reg;
    logic [31:0] limit_reg;

    logic        cfg_wr;
    logic [1:0]  cfg_idx;
    logic        div_start;
    logic        div_busy;
    logic [9:0]  min_interval;

    rsg_pkg::cfg_t      cfg;
    rsg_pkg::in_item_t  in_data_reg;
    logic               in_valid_reg;
    rsg_pkg::out_item_t out_data_reg;
    logic               out_valid_reg;
    rsg_pkg::out_item_t core_result;
    logic               advance;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_idx   = paddr[3:2];
    assign div_start = cfg_wr && cfg_idx == rsg_pkg::REG_MAX_SWITCH_HZ;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_reg    <= 1'b0;
            hz_reg        <= '0;
            safety_en_reg <= 1'b0;
            limit_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                rsg_pkg::REG_INVERT_LEVEL:    invert_reg    <= pwdata[0];
                rsg_pkg::REG_MAX_SWITCH_HZ:   hz_reg        <= pwdata[9:0];
                rsg_pkg::REG_SAFETY_ENABLE:   safety_en_reg <= pwdata[0];
                rsg_pkg::REG_SAFETY_LIMIT_MS: limit_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            rsg_pkg::REG_INVERT_LEVEL:    prdata = {31'd0, invert_reg};
            rsg_pkg::REG_MAX_SWITCH_HZ:   prdata = {22'd0, hz_reg};
            rsg_pkg::REG_SAFETY_ENABLE:   prdata = {31'd0, safety_en_reg};
            rsg_pkg::REG_SAFETY_LIMIT_MS: prdata = limit_reg;
            default:                      prdata = '0;
        endcase
    end

    // min_interval = 1000 / hz, worked out once per write
    rsg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (pwdata[9:0]),
        .busy     (div_busy),
        .quotient (min_interval)
    );

    always_comb
    begin
        cfg.invert_level    = invert_reg;
        cfg.safety_enable   = safety_en_reg;
        cfg.safety_limit_ms = limit_reg;
        cfg.min_interval    = min_interval;
    end

    // Beat in the input register moves on when the result slot is free.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !div_busy && (!in_valid_reg || advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= core_result;
    end

    rsg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_data_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---- checks ----
    // no beat is taken while the interval is being recomputed
    `RSG_ASSERT_NOW(a_busy_blocks_input, div_busy, !in_ready)
    // a safety trip always leaves the relay off and counts as a change
    `RSG_ASSERT_NOW(a_trip_turns_off, out_valid && out_data.safety_tripped,
        !out_data.relay_on && out_data.changed)
    // a refused beat changes nothing unless the safety trip acted
    `RSG_ASSERT_NOW(a_refused_no_change,
        out_valid && out_data.status && !out_data.safety_tripped, !out_data.changed)
    // pin level follows the logical state through the invert setting
    `RSG_ASSERT_NOW(a_pin_polarity, out_valid,
        out_data.pin_level == (out_data.relay_on ^ invert_reg))
    // a stalled beat in the input register is not lost
    `RSG_ASSERT_NEXT(a_input_held, in_valid_reg && !advance, in_valid_reg)

endmodule
